/* rtl/core/text_console_char_engine_unit_assert.svh */
// assertion macros for the console engine back end
`ifndef TEXT_CONSOLE_CHAR_ENGINE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define TCCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define TCCE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/tcce_pkg.sv */
// types, constants and helpers of the text console character engine
`default_nettype none

package tcce_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // field widths
    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = ROW_W + COL_W;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FF        = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] CH_CTRL_LAST = 8'd31;
    localparam logic [CHAR_W-1:0] CH_DEL       = 8'd127;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam int TAB_STEP = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

    typedef enum logic [1:0] {
        OP_KERNEL     = 2'd0,
        OP_KEYBOARD   = 2'd1,
        OP_SET_CURSOR = 2'd2,
        OP_READ_CELL  = 2'd3
    } opcode_t;

    // classified command kinds
    typedef enum logic [3:0] {
        K_PUT,
        K_BACK,
        K_TAB,
        K_LF,
        K_CR,
        K_FF,
        K_NOP,
        K_SETCUR,
        K_READ
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_RUN,
        ST_ERASE,
        ST_READ,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } back_state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
        logic [ROW_W-1:0]  target_row;
        logic [COL_W-1:0]  target_col;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic              status;
    } out_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic              eot;
        logic              in_range;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // linear cell address of a position on screen
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [LIN_W-1:0] lin;
        lin = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/text_console_char_engine_unit.sv */
// top level of the text console character engine
`default_nettype none

// Character-cell text console (80 x 25 cells of {attribute, character}). An item is
// taken at a clock edge with start high and busy low; every item gives exactly one
// result beat, shown on result for one cycle with done high, and the receiver cannot
// hold it off. Items wait in a two-entry command queue while the executor works, so
// busy rises when that queue is full or while the clearing pass after reset runs. The
// executor handles printable characters, tab, carriage return, line feed, set cursor and
// ignored bytes in its run state alone; a backspace that erases a cell and a cell read
// (registered buffer read) pass through an erase or read state. A scroll (line wrap or line
// feed on the last row) walks the buffer one cell per cycle, copying rows up and then
// blanking the last row. A form feed rewrites every cell. After reset a clearing pass runs;
// attribute writes are taken throughout and apply to cells written afterwards.
module text_console_char_engine_unit import tcce_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  in_item_t          item,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data,
    output logic              done,
    output out_item_t         result
);

    logic    push;
    logic    pop;
    logic    q_full;
    logic    init_busy;
    cmd_t    cmd;
    q_head_t head;

    // classify incoming beats
    tcce_front u_front (
        .start     (start),
        .busy      (busy),
        .item      (item),
        .q_full    (q_full),
        .init_busy (init_busy),
        .push      (push),
        .cmd       (cmd)
    );

    // command queue
    tcce_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (cmd),
        .pop    (pop),
        .full   (q_full),
        .head   (head)
    );

    // executor and cell buffer
    tcce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .init_busy   (init_busy),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

endmodule

`default_nettype wire

/* rtl/core/tcce_front.sv */
// front end: takes items and classifies them into commands
`default_nettype none

module tcce_front import tcce_pkg::*; (
    input  logic     start,
    output logic     busy,
    input  in_item_t item,
    input  logic     q_full,
    input  logic     init_busy,
    output logic     push,
    output cmd_t     cmd
);

    logic  printable;
    kind_t char_kind;

    // accept handshake
    assign busy = q_full | init_busy;
    assign push = start & ~busy;

    // character classification
    always_comb
    begin
        printable = (item.char_code > CH_CTRL_LAST) && (item.char_code < CH_DEL);
        char_kind = K_NOP;
        priority if (printable)
        begin
            char_kind = K_PUT;
        end
        else
        begin
            unique case (item.char_code)
                CH_BS:   char_kind = K_BACK;
                CH_TAB:  char_kind = K_TAB;
                CH_LF:   char_kind = K_LF;
                CH_FF:   char_kind = K_FF;
                CH_CR:   char_kind = K_CR;
                default: char_kind = K_NOP;
            endcase
        end
    end

    // command build
    always_comb
    begin
        cmd.ch       = item.char_code;
        cmd.eot      = (item.opcode == OP_KERNEL) && item.end_of_text;
        cmd.row      = item.target_row;
        cmd.col      = item.target_col;
        cmd.in_range = ({1'b0, item.target_row} < (ROW_W + 1)'(ROWS)) &&
                       ({1'b0, item.target_col} < (COL_W + 1)'(COLUMNS));
        cmd.addr     = cell_addr(item.target_row, item.target_col);
        unique case (opcode_t'(item.opcode))
            OP_KERNEL,
            OP_KEYBOARD:   cmd.kind = char_kind;
            OP_SET_CURSOR: cmd.kind = K_SETCUR;
            OP_READ_CELL:  cmd.kind = K_READ;
            default:       cmd.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/tcce_queue.sv */
// short command queue between front and back
`default_nettype none

module tcce_queue import tcce_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    cmd_in,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    cmd_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = entries_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

/* rtl/core/tcce_back.sv */
// back end: cursor, guard, cell buffer and command execution
`default_nettype none
`include "text_console_char_engine_unit_assert.svh"

module tcce_back import tcce_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  q_head_t           head,
    output logic              pop,
    output logic              init_busy,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data,
    output logic              done,
    output out_item_t         result
);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] TAIL_START = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

    back_state_t       state_reg, state_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  guard_row_reg, guard_row_next;
    logic [COL_W-1:0]  guard_col_reg, guard_col_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              done_reg, done_next;
    out_item_t         result_reg, result_next;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    cmd_t              cmd;
    logic              run_item;
    logic              at_last_col;
    logic              at_last_row;
    logic [COL_W:0]    tab_sum;
    logic              bs_moves;
    logic              need_scroll;
    logic              need_clear;
    logic              need_erase;
    logic              need_read;
    logic              bad_pos;
    logic [CELL_W-1:0] blank_cell;
    logic [ADDR_W-1:0] cur_addr;

    assign cmd        = head.cmd;
    assign blank_cell = {attr_reg, CH_SPACE};
    assign cur_addr   = cell_addr(cur_row_reg, cur_col_reg);
    assign init_busy  = (state_reg == ST_INIT);
    assign done       = done_reg;
    assign result     = result_reg;

    // decode of the command at the queue head
    always_comb
    begin
        run_item    = (state_reg == ST_RUN) && head.valid;
        at_last_col = (cur_col_reg == LAST_COL);
        at_last_row = (cur_row_reg == LAST_ROW);
        tab_sum     = {1'b0, cur_col_reg} + (COL_W + 1)'(TAB_STEP);
        if (guard_row_reg == cur_row_reg)
            bs_moves = (cur_col_reg > guard_col_reg);
        else
            bs_moves = (guard_row_reg < cur_row_reg);
        need_scroll = ((cmd.kind == K_PUT) && at_last_col && at_last_row) ||
                      ((cmd.kind == K_LF) && at_last_row);
        need_clear  = (cmd.kind == K_FF);
        need_erase  = (cmd.kind == K_BACK) && bs_moves;
        need_read   = (cmd.kind == K_READ) && cmd.in_range;
        bad_pos     = ((cmd.kind == K_SETCUR) || (cmd.kind == K_READ)) && !cmd.in_range;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (ptr_reg == LAST_CELL)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (run_item)
                begin
                    priority if (need_scroll)
                        state_next = ST_COPY;
                    else if (need_clear)
                        state_next = ST_FILL;
                    else if (need_erase)
                        state_next = ST_ERASE;
                    else if (need_read)
                        state_next = ST_READ;
                    else
                        state_next = ST_RUN;
                end
            end
            ST_ERASE: state_next = ST_RUN;
            ST_READ:  state_next = ST_RUN;
            ST_COPY:
            begin
                if (ptr_reg == COPY_LAST)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_FILL;
            ST_FILL:
            begin
                if (ptr_reg == LAST_CELL)
                    state_next = ST_RUN;
            end
            default:  state_next = ST_RUN;
        endcase
    end

    // datapath, buffer port and result
    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        guard_row_next = guard_row_reg;
        guard_col_next = guard_col_reg;
        ptr_next       = ptr_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr;
        mem_wdata      = blank_cell;
        mem_raddr      = cmd.addr;
        done_next      = 1'b0;
        result_next    = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = RESET_CELL;
                ptr_next  = ptr_reg + 1'b1;
            end
            ST_RUN:
            begin
                if (run_item)
                begin
                    pop = 1'b1;
                    unique case (cmd.kind)
                        K_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {attr_reg, cmd.ch};
                            if (!at_last_col)
                                cur_col_next = cur_col_reg + 1'b1;
                            else if (!at_last_row)
                            begin
                                cur_row_next = cur_row_reg + 1'b1;
                                cur_col_next = '0;
                            end
                        end
                        K_BACK:
                        begin
                            if (bs_moves)
                            begin
                                if (cur_col_reg != '0)
                                    cur_col_next = cur_col_reg - 1'b1;
                                else
                                begin
                                    cur_row_next = cur_row_reg - 1'b1;
                                    cur_col_next = LAST_COL;
                                end
                            end
                        end
                        K_TAB:
                        begin
                            if (tab_sum < (COL_W + 1)'(COLUMNS - 1))
                                cur_col_next = (cur_col_reg & ~COL_W'(TAB_STEP - 1)) +
                                               COL_W'(TAB_STEP);
                            else
                                cur_col_next = LAST_COL;
                        end
                        K_LF:
                        begin
                            if (!at_last_row)
                            begin
                                cur_row_next = cur_row_reg + 1'b1;
                                cur_col_next = '0;
                            end
                        end
                        K_CR:
                        begin
                            cur_col_next = '0;
                        end
                        K_FF:
                        begin
                            ptr_next = '0;
                        end
                        K_SETCUR:
                        begin
                            if (cmd.in_range)
                            begin
                                cur_row_next = cmd.row;
                                cur_col_next = cmd.col;
                            end
                        end
                        K_READ,
                        K_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase

                    // scroll moves the cursor to the start of the last row
                    if (need_scroll)
                    begin
                        ptr_next     = '0;
                        cur_row_next = LAST_ROW;
                        cur_col_next = '0;
                        if (guard_row_reg != '0)
                            guard_row_next = guard_row_reg - 1'b1;
                        else
                            guard_col_next = '0;
                    end

                    // end of kernel string pins the guard to the cursor
                    if (cmd.eot)
                    begin
                        guard_row_next = cur_row_next;
                        guard_col_next = cur_col_next;
                    end

                    done_next = !(need_scroll || need_clear || need_erase || need_read);
                    result_next.status = bad_pos;
                end
            end
            ST_ERASE:
            begin
                mem_we    = 1'b1;
                done_next = 1'b1;
            end
            ST_READ:
            begin
                done_next             = 1'b1;
                result_next.cell_char = rd_data_reg[CHAR_W-1:0];
                result_next.cell_attr = rd_data_reg[CELL_W-1:CHAR_W];
            end
            ST_COPY:
            begin
                mem_raddr = ptr_reg + ADDR_W'(COLUMNS);
                mem_we    = (ptr_reg != '0);
                mem_waddr = ptr_reg - 1'b1;
                mem_wdata = rd_data_reg;
                ptr_next  = ptr_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - 1'b1;
                mem_wdata = rd_data_reg;
                ptr_next  = TAIL_START;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                ptr_next  = ptr_reg + 1'b1;
                done_next = (ptr_reg == LAST_CELL);
            end
            default:
            begin
            end
        endcase

        result_next.cursor_row = cur_row_next;
        result_next.cursor_col = cur_col_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            guard_row_reg <= '0;
            guard_col_reg <= '0;
            attr_reg      <= ATTR_RESET;
            ptr_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            guard_row_reg <= guard_row_next;
            guard_col_reg <= guard_col_next;
            ptr_reg       <= ptr_next;
            done_reg      <= done_next;
            if (cfg_wr_en)
                attr_reg <= cfg_wr_data;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // cell buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // checks
    `TCCE_ASSERT(a_cursor_bounds, (cur_row_reg < ROWS) && (cur_col_reg < COLUMNS), "cursor off screen")
    `TCCE_ASSERT(a_guard_bounds, (guard_row_reg < ROWS) && (guard_col_reg < COLUMNS), "guard off screen")
    `TCCE_ASSERT(a_copy_addr, !(mem_we && (state_reg == ST_COPY)) || (mem_waddr < TAIL_START), "scroll copy hit last row")
    `TCCE_ASSERT_NEXT(a_init_hold, (state_reg == ST_INIT) && (ptr_reg != LAST_CELL), state_reg == ST_INIT, "clear pass ended early")
    `TCCE_ASSERT(a_done_idle, !done_reg || (state_reg == ST_RUN), "result beat while work pending")

endmodule

`default_nettype wire

/* dv/text_console_char_engine_unit_tb.sv */
// self-checking testbench for the text console character engine
`timescale 1ns / 100ps

module text_console_char_engine_unit_tb;
    import tcce_pkg::*;

    // wait before an attribute write, long enough for a full buffer walk
    localparam int SETTLE_CYCLES = CELLS + 16;
    // bound on scrolls and clears so the run stays short
    localparam int HEAVY_CAP = 120;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    in_item_t          item = '0;
    logic              cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0] cfg_wr_data = '0;
    logic              done;
    out_item_t         result;

    text_console_char_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    always #5 clk = ~clk;

    // shadow copy of screen, cursor, protect point and attribute
    logic [CELL_W-1:0] shadow_cells [CELLS];
    logic [ATTR_W-1:0] shadow_attr;
    int cur_row = 0;
    int cur_col = 0;
    int guard_row = 0;
    int guard_col = 0;

    // reports predicted for accepted beats, oldest first
    out_item_t awaited_reports [$];

    int gap_pct = 0;
    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int scroll_count = 0;
    int clear_count = 0;
    int attr_writes = 0;

    // write one cell with the current attribute, off-screen writes dropped
    function automatic void put_cell(input int row, input int col, input logic [CHAR_W-1:0] ch);
        if (row < ROWS && col < COLUMNS)
        begin
            shadow_cells[row * COLUMNS + col] = {shadow_attr, ch};
        end
    endfunction

    // move every row up by one and blank the bottom row
    function automatic void shadow_scroll();
        for (int i = 0; i < CELLS - COLUMNS; i++)
        begin
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        end
        for (int c = 0; c < COLUMNS; c++)
        begin
            put_cell(ROWS - 1, c, CH_SPACE);
        end
        cur_row = ROWS - 1;
        cur_col = 0;
        if (guard_row >= 1)
        begin
            guard_row = guard_row - 1;
        end
        else
        begin
            guard_row = 0;
            guard_col = 0;
        end
        scroll_count++;
    endfunction

    // effect of one character byte on the shadow
    function automatic void take_char(input logic [CHAR_W-1:0] ch);
        if (ch > CH_CTRL_LAST && ch < CH_DEL)
        begin
            put_cell(cur_row, cur_col, ch);
            cur_col++;
            if (cur_col > COLUMNS - 1)
            begin
                cur_row++;
                cur_col = 0;
            end
            if (cur_row >= ROWS)
            begin
                shadow_scroll();
            end
        end
        else
        begin
            case (ch)
                CH_BS:
                begin
                    // erase stops at the protect point, nothing above it
                    if (guard_row == cur_row)
                    begin
                        if (cur_col > guard_col)
                        begin
                            cur_col--;
                            put_cell(cur_row, cur_col, CH_SPACE);
                        end
                    end
                    else if (guard_row < cur_row)
                    begin
                        if (cur_col > 0)
                        begin
                            cur_col--;
                        end
                        else
                        begin
                            cur_row--;
                            cur_col = COLUMNS - 1;
                        end
                        put_cell(cur_row, cur_col, CH_SPACE);
                    end
                end
                CH_TAB:
                begin
                    if (cur_col + TAB_STEP < COLUMNS - 1)
                    begin
                        cur_col = cur_col + (TAB_STEP - cur_col % TAB_STEP);
                    end
                    else
                    begin
                        cur_col = COLUMNS - 1;
                    end
                end
                CH_LF:
                begin
                    if (cur_row < ROWS - 1)
                    begin
                        cur_row++;
                        cur_col = 0;
                    end
                    else
                    begin
                        shadow_scroll();
                    end
                end
                CH_FF:
                begin
                    for (int i = 0; i < CELLS; i++)
                    begin
                        shadow_cells[i] = {shadow_attr, CH_SPACE};
                    end
                    clear_count++;
                end
                CH_CR:
                begin
                    cur_col = 0;
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    // apply one accepted beat to the shadow and return the report it gives
    function automatic out_item_t console_apply(input in_item_t it);
        out_item_t rep;
        int trow;
        int tcol;
        logic [CELL_W-1:0] word;
        rep = '0;
        trow = it.target_row;
        tcol = it.target_col;
        if (it.opcode == OP_KERNEL || it.opcode == OP_KEYBOARD)
        begin
            take_char(it.char_code);
            if (it.opcode == OP_KERNEL && it.end_of_text)
            begin
                guard_row = cur_row;
                guard_col = cur_col;
            end
        end
        else if (it.opcode == OP_SET_CURSOR)
        begin
            if (trow >= ROWS || tcol >= COLUMNS)
            begin
                rep.status = 1'b1;
            end
            else
            begin
                cur_row = trow;
                cur_col = tcol;
            end
        end
        else
        begin
            if (trow >= ROWS || tcol >= COLUMNS)
            begin
                rep.status = 1'b1;
            end
            else
            begin
                word = shadow_cells[trow * COLUMNS + tcol];
                rep.cell_char = word[CHAR_W-1:0];
                rep.cell_attr = word[CELL_W-1:CHAR_W];
            end
        end
        rep.cursor_row = ROW_W'(cur_row);
        rep.cursor_col = COL_W'(cur_col);
        return rep;
    endfunction

    function automatic in_item_t cmd_item(input opcode_t op, input logic [CHAR_W-1:0] ch,
                                          input logic eot, input int row, input int col);
        return '{opcode: op, char_code: ch, end_of_text: eot,
                 target_row: ROW_W'(row), target_col: COL_W'(col)};
    endfunction

    // every field random over its full width
    function automatic in_item_t noise_item();
        return '{opcode: 2'($urandom_range(3)), char_code: CHAR_W'($urandom_range(255)),
                 end_of_text: 1'($urandom_range(1)),
                 target_row: ROW_W'($urandom_range(2 ** ROW_W - 1)),
                 target_col: COL_W'($urandom_range(2 ** COL_W - 1))};
    endfunction

    // character mix of typed text, backspace share given in percent
    function automatic logic [CHAR_W-1:0] typed_char(input int bs_pct);
        int r;
        if ($urandom_range(299) == 0)
        begin
            return CH_FF;
        end
        r = $urandom_range(99);
        if (r < bs_pct)
        begin
            return CH_BS;
        end
        if (r < bs_pct + 4)
        begin
            return CH_TAB;
        end
        if (r < bs_pct + 8)
        begin
            return CH_LF;
        end
        if (r < bs_pct + 11)
        begin
            return CH_CR;
        end
        if (r < bs_pct + 15)
        begin
            return CHAR_W'($urandom_range(255));
        end
        return CHAR_W'($urandom_range(CH_DEL - 1, CH_SPACE));
    endfunction

    // send one beat, with a random gap first, and record its report
    task automatic push_beat(input in_item_t it);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
            begin
                @(posedge clk);
            end
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        awaited_reports.push_back(console_apply(it));
        beats_sent++;
    endtask

    // attribute write once the engine has drained
    task automatic change_attribute(input logic [ATTR_W-1:0] value);
        start <= 1'b0;
        while (awaited_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_attr = value;
        attr_writes++;
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && done)
        begin
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
                errors++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                check_field("cursor_row", want.cursor_row, result.cursor_row);
                check_field("cursor_col", want.cursor_col, result.cursor_col);
                check_field("cell_char", want.cell_char, result.cell_char);
                check_field("cell_attr", want.cell_attr, result.cell_attr);
                check_field("status", want.status, result.status);
                beats_checked++;
            end
        end
    end

    // printable extremes, ignored bytes and the line wrap
    task automatic test_printable_and_wrap();
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, 0, COLUMNS - 1));
        // end of text has no effect on keyboard input
        push_beat(cmd_item(OP_KEYBOARD, 8'h41, 1'b1, 0, 0));
        push_beat(cmd_item(OP_KERNEL, CH_SPACE, 1'b0, 0, 0));
        push_beat(cmd_item(OP_KERNEL, CHAR_W'(CH_DEL - 1), 1'b0, 0, 0));
        push_beat(cmd_item(OP_KEYBOARD, CH_DEL, 1'b0, 0, 0));
        push_beat(cmd_item(OP_KERNEL, 8'hFF, 1'b0, 0, 0));
        push_beat(cmd_item(OP_READ_CELL, 8'h00, 1'b0, 0, COLUMNS - 1));
    endtask

    // tab stops, carriage return, scroll by wrap and by line feed, form feed
    task automatic test_control_codes();
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, 2, 70));
        push_beat(cmd_item(OP_KEYBOARD, CH_TAB, 1'b0, 0, 0));
        push_beat(cmd_item(OP_KEYBOARD, CH_TAB, 1'b0, 0, 0));
        push_beat(cmd_item(OP_KERNEL, CH_CR, 1'b0, 0, 0));
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, ROWS - 1, COLUMNS - 1));
        push_beat(cmd_item(OP_KERNEL, 8'h23, 1'b0, 0, 0));
        push_beat(cmd_item(OP_KEYBOARD, CH_LF, 1'b0, 0, 0));
        push_beat(cmd_item(OP_READ_CELL, 8'h00, 1'b0, ROWS - 3, COLUMNS - 1));
        push_beat(cmd_item(OP_KERNEL, CH_FF, 1'b0, 0, 0));
    endtask

    // backspace on, below and above the protect row
    task automatic test_guard_and_backspace();
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, 3, 0));
        push_beat(cmd_item(OP_KERNEL, 8'h6B, 1'b1, 0, 0));
        push_beat(cmd_item(OP_KEYBOARD, 8'h7A, 1'b0, 0, 0));
        push_beat(cmd_item(OP_KEYBOARD, CH_BS, 1'b0, 0, 0));
        push_beat(cmd_item(OP_KEYBOARD, CH_BS, 1'b0, 0, 0));
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, 5, 0));
        push_beat(cmd_item(OP_KEYBOARD, CH_BS, 1'b0, 0, 0));
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, 1, 5));
        push_beat(cmd_item(OP_KEYBOARD, CH_BS, 1'b0, 0, 0));
    endtask

    // positions past the last row or column
    task automatic test_position_bounds();
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, ROWS, 0));
        push_beat(cmd_item(OP_SET_CURSOR, 8'h00, 1'b0, 0, COLUMNS));
        push_beat(cmd_item(OP_READ_CELL, 8'h00, 1'b0, 2 ** ROW_W - 1, 2 ** COL_W - 1));
    endtask

    // random sequences of typed text, kernel strings, moves and reads
    task automatic test_random_traffic(input int gap, input int count,
                                       input logic [ATTR_W-1:0] attr_first,
                                       input logic [ATTR_W-1:0] attr_second);
        in_item_t episode [$];
        in_item_t it;
        int sent;
        int kind;
        int n;
        int pick;
        bit switched;
        gap_pct = gap;
        change_attribute(attr_first);
        sent = 0;
        switched = 1'b0;
        while (sent < count)
        begin
            if (!switched && sent >= count / 2)
            begin
                change_attribute(attr_second);
                switched = 1'b1;
            end
            episode.delete();
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                // kernel string closed by end of text
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++)
                begin
                    it = noise_item();
                    it.opcode = OP_KERNEL;
                    it.char_code = typed_char(3);
                    it.end_of_text = (i == n - 1) || ($urandom_range(19) == 0);
                    episode.push_back(it);
                end
            end
            else if (kind < 60)
            begin
                // keyboard typing with frequent erase
                n = $urandom_range(16, 1);
                for (int i = 0; i < n; i++)
                begin
                    it = noise_item();
                    it.opcode = OP_KEYBOARD;
                    it.char_code = typed_char(25);
                    episode.push_back(it);
                end
            end
            else if (kind < 75)
            begin
                // cursor move, often followed by a kernel mark there
                it = noise_item();
                it.opcode = OP_SET_CURSOR;
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    it.target_row = ROW_W'(ROWS - 1);
                    it.target_col = COL_W'($urandom_range(COLUMNS - 1));
                end
                else if (pick < 85)
                begin
                    it.target_row = ROW_W'($urandom_range(ROWS - 1));
                    it.target_col = COL_W'($urandom_range(COLUMNS - 1));
                end
                episode.push_back(it);
                if ($urandom_range(1) == 1)
                begin
                    it = noise_item();
                    it.opcode = OP_KERNEL;
                    it.char_code = CHAR_W'($urandom_range(CH_DEL - 1, CH_SPACE));
                    it.end_of_text = 1'b1;
                    episode.push_back(it);
                end
            end
            else if (kind < 90)
            begin
                // reads near the cursor, anywhere, or out of range
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++)
                begin
                    it = noise_item();
                    it.opcode = OP_READ_CELL;
                    pick = $urandom_range(9);
                    if (pick < 5)
                    begin
                        it.target_row = ROW_W'(cur_row);
                        it.target_col = COL_W'(cur_col > 0 ? cur_col - 1 : 0);
                    end
                    else if (pick < 8)
                    begin
                        it.target_row = ROW_W'($urandom_range(ROWS - 1));
                        it.target_col = COL_W'($urandom_range(COLUMNS - 1));
                    end
                    episode.push_back(it);
                end
            end
            else
            begin
                episode.push_back(noise_item());
            end

            foreach (episode[i])
            begin
                it = episode[i];
                // past the cap, turn buffer walks into a carriage return
                if (scroll_count + clear_count >= HEAVY_CAP &&
                    (it.opcode == OP_KERNEL || it.opcode == OP_KEYBOARD) &&
                    (it.char_code == CH_FF ||
                     (cur_row == ROWS - 1 &&
                      (it.char_code == CH_LF ||
                       (it.char_code > CH_CTRL_LAST && it.char_code < CH_DEL &&
                        cur_col == COLUMNS - 1)))))
                begin
                    it.char_code = CH_CR;
                end
                push_beat(it);
                sent++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_cells[i] = RESET_CELL;
        end
        shadow_attr = ATTR_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass after reset holds busy high
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end

        gap_pct = 19;
        change_attribute(8'h1E);
        test_printable_and_wrap();
        test_control_codes();
        test_guard_and_backspace();
        test_position_bounds();

        test_random_traffic(19, 500, 8'h00, 8'hFF);
        test_random_traffic(72, 500, ATTR_W'($urandom_range(255)), 8'h00);
        test_random_traffic(0, 500, 8'hFF, ATTR_W'($urandom_range(255)));

        start <= 1'b0;
        while (awaited_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d command beats and %0d result beats checked",
                 beats_sent, beats_checked);
        $display("including %0d scrolls, %0d screen clears and %0d attribute settings",
                 scroll_count, clear_count, attr_writes);
        if (errors == 0)
        begin
            $display("text_console_char_engine_unit test passed");
        end
        else
        begin
            $display("text_console_char_engine_unit test failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("text_console_char_engine_unit test failed");
        $finish;
    end

endmodule
